[rtl/drivetrain_thermal_step_core_assert.svh]
// ----------------------------------------------------------------------------
// drivetrain thermal step assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef DRIVETRAIN_THERMAL_STEP_CORE_ASSERT_SVH
`define DRIVETRAIN_THERMAL_STEP_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define DTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define DTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// what follows a reset edge
`define DTS_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

[rtl/dts_pkg.sv]
// ----------------------------------------------------------------------------
// dts_pkg
// types and fixed constants of the drivetrain thermal step core
// ----------------------------------------------------------------------------
package dts_pkg;

    typedef enum logic [2:0] {
        CFG_GEAR_TABLE   = 3'd0,
        CFG_FINAL_DRIVE  = 3'd1,
        CFG_BASE_EFF     = 3'd2,
        CFG_HEALTH       = 3'd3,
        CFG_WHEEL_RADIUS = 3'd4,
        CFG_COOLING      = 3'd5,
        CFG_AMBIENT      = 3'd6,
        CFG_THERMAL_CAP  = 3'd7
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // micro-op sequence of one step
    typedef enum logic [4:0] {
        OP_H_MUL    = 5'd0,
        OP_FACTOR   = 5'd1,
        OP_EFF_MUL  = 5'd2,
        OP_EFF_CAP  = 5'd3,
        OP_T_FD     = 5'd4,
        OP_T_EFF    = 5'd5,
        OP_T_K1000  = 5'd6,
        OP_T_DIV    = 5'd7,
        OP_TRACTION = 5'd8,
        OP_NET      = 5'd9,
        OP_NET_DT   = 5'd10,
        OP_V_DIV    = 5'd11,
        OP_SPEED    = 5'd12,
        OP_W_HI     = 5'd13,
        OP_W_LO     = 5'd14,
        OP_W_SUM    = 5'd15,
        OP_W_DIV    = 5'd16,
        OP_WHEEL    = 5'd17,
        OP_G_FD     = 5'd18,
        OP_G_RATIO  = 5'd19,
        OP_GBOX     = 5'd20,
        OP_P_TQ     = 5'd21,
        OP_P_K      = 5'd22,
        OP_LOSS_MUL = 5'd23,
        OP_LOSS     = 5'd24,
        OP_COOL     = 5'd25,
        OP_HEAT     = 5'd26,
        OP_HEAT_DT  = 5'd27,
        OP_TMP_DIV  = 5'd28,
        OP_TEMP     = 5'd29
    } t_op;

    localparam int unsigned CFG_DATA_W = 60;
    localparam int unsigned RATIO_W    = 12;

    localparam logic [16:0] EFF_ONE     = 17'd65536;
    localparam logic [16:0] HEALTH_BASE = 17'd26214;
    localparam logic [16:0] HEALTH_SPAN = 17'd39322;
    localparam logic [16:0] TRACTION_K  = 17'd1000;
    localparam logic [16:0] RADS_K      = 17'd6863;
    // 39113919 split as hi * 8192 + lo
    localparam logic [16:0] WHEEL_K_HI  = 17'd4774;
    localparam logic [16:0] WHEEL_K_LO  = 17'd5311;

    localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;
    localparam logic [19:0] WHEEL_MAX = 20'hFFFFF;
    localparam logic [23:0] GBOX_MAX  = 24'hFFFFFF;
    localparam logic signed [41:0] TEMP_MAX = 42'sd8388607;
    localparam logic signed [41:0] TEMP_MIN = -42'sd8388608;

    localparam logic [11:0] RST_FINAL_DRIVE = 12'd1024;
    localparam logic [16:0] RST_BASE_EFF    = 17'd62259;
    localparam logic [16:0] RST_HEALTH      = 17'd65536;
    localparam logic [10:0] RST_RADIUS      = 11'd300;
    localparam logic [15:0] RST_COOLING     = 16'd2560;
    localparam logic [15:0] RST_AMBIENT     = 16'd6400;
    localparam logic [19:0] RST_CAPACITY    = 20'd20000;
    localparam logic [23:0] RST_TEMP        = 24'd6400;

    localparam logic [5:0] DIV_LAST = 6'd63;

endpackage

[rtl/drivetrain_thermal_step_core.sv]
// ----------------------------------------------------------------------------
// drivetrain_thermal_step_core
// gearbox, vehicle speed and gearbox temperature integrator, one tick a transfer
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_ready carry one tick (time step, clutch
// torque, gear select, mass, brake force); a transfer starts one step
// output channel: o_out_valid / i_out_ready carry one result per tick
// config port: i_cfg_we writes register i_cfg_index with i_cfg_data at once
// a tick runs 30 micro-ops on one shared 48x17 multiplier and four passes of
// a radix-2 divider; a division is skipped on a zero ratio or radius, zero
// mass, zero radius or zero capacity
// o_in_ready is high only between steps; one result may wait in the output
// register while the next tick is taken and computed
// a stalled receiver holds the next step in its last cycle until the output
// register frees, outputs stay stable meanwhile
// reset clears o_out_valid, raises o_in_ready, loads the register defaults,
// speed 0 and temperature 25 C
// ----------------------------------------------------------------------------
module drivetrain_thermal_step_core #(
    parameter int GEAR_COUNT = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  dts_pkg::t_cfg_index           i_cfg_index,
    input  logic [dts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [15:0]                   i_time_step,
    input  logic signed [15:0]            i_clutch_torque,
    input  logic [2:0]                    i_gear_select,
    input  logic [15:0]                   i_vehicle_mass,
    input  logic signed [19:0]            i_brake_force,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_gear_engaged,
    output logic [23:0]                   o_vehicle_speed,
    output logic [19:0]                   o_wheel_rpm,
    output logic [23:0]                   o_gearbox_rpm,
    output logic signed [23:0]            o_gearbox_temperature
);
    import dts_pkg::*;

    localparam logic [2:0] GEAR_LAST = 3'(GEAR_COUNT);

    // configuration registers
    logic [59:0]        r_gear_table;
    logic [11:0]        r_fd;
    logic [16:0]        r_base_eff;
    logic [16:0]        r_health;
    logic [10:0]        r_radius;
    logic [15:0]        r_cool;
    logic signed [15:0] r_amb;
    logic [19:0]        r_cap;

    // state carried between ticks
    logic [23:0]        r_speed;
    logic signed [23:0] r_temp;

    // sequencer
    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [5:0] r_dcnt;

    // latched tick
    logic [15:0]        r_dt;
    logic               r_tneg;
    logic [15:0]        r_tmag;
    logic [2:0]         r_gear;
    logic [11:0]        r_ratio;
    logic [15:0]        r_mass;
    logic signed [19:0] r_brake;

    // working registers
    logic [63:0]        r_x;
    logic [63:0]        r_y;
    logic [16:0]        r_eff;
    logic signed [40:0] r_trac;
    logic               r_nneg;
    logic [19:0]        r_wheel;
    logic [23:0]        r_gbox;
    logic               r_dneg;
    logic [24:0]        r_dmag;
    logic               r_hneg;

    // divider
    logic [63:0] r_quo;
    logic [19:0] r_rem;
    logic [19:0] r_dvsr;

    // output register
    logic               r_out_valid;
    logic [2:0]         r_out_gear;
    logic [23:0]        r_out_speed;
    logic [19:0]        r_out_wheel;
    logic [23:0]        r_out_gbox;
    logic signed [23:0] r_out_temp;

    logic        w_in_xfer;
    logic        w_out_free;
    logic        w_gear_ok;
    logic [2:0]  w_gear_idx;
    logic [16:0] w_health;
    logic [47:0] w_ma;
    logic [16:0] w_mb;
    logic [64:0] w_prod;
    logic        w_div_op;
    logic        w_div_go;
    logic [63:0] w_dvd;
    logic [19:0] w_dvs;
    logic [20:0] w_try;
    logic [20:0] w_diff;
    logic        w_sub_ok;
    logic [39:0] w_f;
    logic signed [41:0] w_brk;
    logic signed [41:0] w_net;
    logic [41:0] w_netmag;
    logic [47:0] w_dv;
    logic signed [49:0] w_vsum;
    logic [23:0] w_speed_new;
    logic [39:0] w_wq;
    logic signed [24:0] w_d;
    logic [49:0] w_hy;
    logic [49:0] w_hc;
    logic [49:0] w_heat;
    logic [49:0] w_heatmag;
    logic [39:0] w_dtq;
    logic signed [41:0] w_tsum;
    logic signed [41:0] w_tsat;
    logic signed [41:0] w_amb_ext;
    logic signed [23:0] w_temp_new;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // gear decode, neutral outside 1..GEAR_COUNT
    assign w_gear_ok  = (i_gear_select != 3'd0) && (i_gear_select <= GEAR_LAST);
    assign w_gear_idx = i_gear_select - 3'd1;
    assign w_health   = (r_health > EFF_ONE) ? EFF_ONE : r_health;

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_op)
            OP_H_MUL:    begin w_ma = {31'b0, w_health};   w_mb = HEALTH_SPAN; end
            OP_EFF_MUL:  begin w_ma = {31'b0, r_base_eff}; w_mb = r_x[16:0]; end
            OP_EFF_CAP:  begin w_ma = {32'b0, r_tmag};     w_mb = {5'b0, r_ratio}; end
            OP_T_FD:     begin w_ma = r_y[47:0];           w_mb = {5'b0, r_fd}; end
            OP_T_EFF:    begin w_ma = r_y[47:0];           w_mb = r_eff; end
            OP_T_K1000:  begin w_ma = r_y[63:16];          w_mb = TRACTION_K; end
            OP_NET_DT:   begin w_ma = r_x[47:0];           w_mb = {1'b0, r_dt}; end
            OP_W_HI:     begin w_ma = {24'b0, r_speed};    w_mb = WHEEL_K_HI; end
            OP_W_LO:     begin w_ma = {24'b0, r_speed};    w_mb = WHEEL_K_LO; end
            OP_G_FD:     begin w_ma = {28'b0, r_wheel};    w_mb = {5'b0, r_fd}; end
            OP_G_RATIO:  begin w_ma = r_x[47:0];           w_mb = {5'b0, r_ratio}; end
            OP_P_TQ:     begin w_ma = {24'b0, r_gbox};     w_mb = {1'b0, r_tmag}; end
            OP_P_K:      begin w_ma = r_x[47:0];           w_mb = RADS_K; end
            OP_LOSS_MUL: begin w_ma = r_x[63:16];          w_mb = EFF_ONE - r_eff; end
            OP_COOL:     begin w_ma = {23'b0, r_dmag};     w_mb = {1'b0, r_cool}; end
            OP_HEAT_DT:  begin w_ma = r_x[47:0];           w_mb = {1'b0, r_dt}; end
            default:     begin w_ma = '0;                  w_mb = '0; end
        endcase
    end

    assign w_prod = 65'(w_ma) * 65'(w_mb);

    // divider launch: dividend, divisor and whether the pass runs at all
    always_comb begin
        w_div_op = 1'b0;
        w_div_go = 1'b0;
        w_dvd    = r_x;
        w_dvs    = '0;
        case (r_op)
            OP_T_DIV: begin
                w_div_op = 1'b1;
                w_div_go = (r_ratio != '0) && (r_radius != '0);
                w_dvd    = r_y;
                w_dvs    = {9'b0, r_radius};
            end
            OP_V_DIV: begin
                w_div_op = 1'b1;
                w_div_go = (r_mass != '0);
                w_dvs    = {4'b0, r_mass};
            end
            OP_W_DIV: begin
                w_div_op = 1'b1;
                w_div_go = (r_radius != '0);
                w_dvs    = {9'b0, r_radius};
            end
            OP_TMP_DIV: begin
                w_div_op = 1'b1;
                w_div_go = (r_cap != '0);
                w_dvs    = r_cap;
            end
            default: begin
                w_div_op = 1'b0;
            end
        endcase
    end

    // one restoring step per cycle
    assign w_try    = {r_rem, r_quo[63]};
    assign w_diff   = w_try - {1'b0, r_dvsr};
    assign w_sub_ok = (w_try >= {1'b0, r_dvsr});

    // traction and net force
    assign w_f      = r_quo[51:12];
    assign w_brk    = {{14{r_brake[19]}}, r_brake, 8'b0};
    assign w_net    = {r_trac[40], r_trac} - w_brk;
    assign w_netmag = w_net[41] ? 42'(-w_net) : 42'(w_net);

    // speed integrate, floor 0, saturate
    assign w_dv   = r_quo[55:8];
    assign w_vsum = $signed({26'b0, r_speed})
                  + (r_nneg ? -$signed({2'b0, w_dv}) : $signed({2'b0, w_dv}));
    always_comb begin
        if (w_vsum[49]) begin
            w_speed_new = '0;
        end else if (w_vsum > $signed({26'b0, SPEED_MAX})) begin
            w_speed_new = SPEED_MAX;
        end else begin
            w_speed_new = w_vsum[23:0];
        end
    end

    assign w_wq = r_quo[63:24];

    // temperature difference and heat balance
    assign w_d       = {r_temp[23], r_temp} - {{9{r_amb[15]}}, r_amb};
    assign w_hy      = {2'b0, r_y[47:0]};
    assign w_hc      = {9'b0, r_x[40:0]};
    assign w_heat    = r_dneg ? (w_hy + w_hc) : (w_hy - w_hc);
    assign w_heatmag = w_heat[49] ? (~w_heat + 50'd1) : w_heat;

    // temperature integrate, saturate, floor at ambient
    assign w_dtq     = r_quo[63:24];
    assign w_tsum    = {{18{r_temp[23]}}, r_temp}
                     + (r_hneg ? -$signed({2'b0, w_dtq}) : $signed({2'b0, w_dtq}));
    assign w_amb_ext = {{26{r_amb[15]}}, r_amb};
    always_comb begin
        if (w_tsum > TEMP_MAX) begin
            w_tsat = TEMP_MAX;
        end else if (w_tsum < TEMP_MIN) begin
            w_tsat = TEMP_MIN;
        end else begin
            w_tsat = w_tsum;
        end
        if (w_tsat < w_amb_ext) begin
            w_temp_new = w_amb_ext[23:0];
        end else begin
            w_temp_new = w_tsat[23:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_CALC;
                    n_op    = OP_H_MUL;
                end
            end
            ST_CALC: begin
                if (r_op == OP_TEMP) begin
                    n_state = ST_DONE;
                end else begin
                    n_op = t_op'(5'(r_op) + 5'd1);
                    if (w_div_op && w_div_go) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (r_dcnt == DIV_LAST) begin
                    n_state = ST_CALC;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control, configuration and carried state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_op         <= OP_H_MUL;
            r_dcnt       <= '0;
            r_out_valid  <= 1'b0;
            r_gear_table <= '0;
            r_fd         <= RST_FINAL_DRIVE;
            r_base_eff   <= RST_BASE_EFF;
            r_health     <= RST_HEALTH;
            r_radius     <= RST_RADIUS;
            r_cool       <= RST_COOLING;
            r_amb        <= RST_AMBIENT;
            r_cap        <= RST_CAPACITY;
            r_speed      <= '0;
            r_temp       <= RST_TEMP;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;

            if (r_state == ST_DIV) begin
                r_dcnt <= (r_dcnt == DIV_LAST) ? 6'd0 : r_dcnt + 6'd1;
            end

            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GEAR_TABLE:   r_gear_table <= i_cfg_data[59:0];
                    CFG_FINAL_DRIVE:  r_fd         <= i_cfg_data[11:0];
                    CFG_BASE_EFF:     r_base_eff   <= i_cfg_data[16:0];
                    CFG_HEALTH:       r_health     <= i_cfg_data[16:0];
                    CFG_WHEEL_RADIUS: r_radius     <= i_cfg_data[10:0];
                    CFG_COOLING:      r_cool       <= i_cfg_data[15:0];
                    CFG_AMBIENT:      r_amb        <= i_cfg_data[15:0];
                    CFG_THERMAL_CAP:  r_cap        <= i_cfg_data[19:0];
                    default:          r_cap        <= r_cap;
                endcase
            end

            if (r_state == ST_CALC && r_op == OP_SPEED) begin
                r_speed <= w_speed_new;
            end
            if (r_state == ST_CALC && r_op == OP_TEMP) begin
                r_temp <= w_temp_new;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_dt    <= i_time_step;
            r_tneg  <= i_clutch_torque[15];
            r_tmag  <= i_clutch_torque[15] ? 16'(-i_clutch_torque) : i_clutch_torque;
            r_mass  <= i_vehicle_mass;
            r_brake <= i_brake_force;
            r_gear  <= w_gear_ok ? i_gear_select : 3'd0;
            r_ratio <= w_gear_ok ? r_gear_table[RATIO_W*w_gear_idx +: RATIO_W] : 12'd0;
        end

        if (r_state == ST_DIV) begin
            r_rem <= w_sub_ok ? w_diff[19:0] : w_try[19:0];
            r_quo <= {r_quo[62:0], w_sub_ok};
        end

        if (r_state == ST_CALC) begin
            if (w_div_op) begin
                // skipped pass leaves a zero quotient
                r_quo  <= w_div_go ? w_dvd : 64'd0;
                r_rem  <= '0;
                r_dvsr <= w_dvs;
            end
            case (r_op)
                OP_H_MUL:    r_x <= w_prod[63:0];
                OP_FACTOR:   r_x <= {47'b0, 17'(r_x[31:16]) + HEALTH_BASE};
                OP_EFF_MUL:  r_x <= w_prod[63:0];
                OP_EFF_CAP: begin
                    r_eff <= (r_x[63:16] > {31'b0, EFF_ONE}) ? EFF_ONE : r_x[32:16];
                    r_y   <= w_prod[63:0];
                end
                OP_T_FD:     r_y <= w_prod[63:0];
                OP_T_EFF:    r_y <= w_prod[63:0];
                OP_T_K1000:  r_y <= w_prod[63:0];
                OP_TRACTION: begin
                    r_trac <= r_tneg ? -$signed({1'b0, w_f}) : $signed({1'b0, w_f});
                end
                OP_NET: begin
                    r_nneg <= w_net[41];
                    r_x    <= {22'b0, w_netmag};
                end
                OP_NET_DT:   r_x <= w_prod[63:0];
                OP_W_HI:     r_x <= w_prod[63:0];
                OP_W_LO:     r_y <= w_prod[63:0];
                OP_W_SUM:    r_x <= {r_x[50:0], 13'b0} + r_y;
                OP_WHEEL: begin
                    r_wheel <= (w_wq > {20'b0, WHEEL_MAX}) ? WHEEL_MAX : w_wq[19:0];
                end
                OP_G_FD:     r_x <= w_prod[63:0];
                OP_G_RATIO:  r_x <= w_prod[63:0];
                OP_GBOX: begin
                    r_gbox <= (r_x[63:16] > {24'b0, GBOX_MAX}) ? GBOX_MAX : r_x[39:16];
                end
                OP_P_TQ:     r_x <= w_prod[63:0];
                OP_P_K:      r_x <= w_prod[63:0];
                OP_LOSS_MUL: r_x <= w_prod[63:0];
                OP_LOSS: begin
                    r_y    <= {8'b0, r_x[63:16], 8'b0};
                    r_dneg <= w_d[24];
                    r_dmag <= w_d[24] ? 25'(-w_d) : 25'(w_d);
                end
                OP_COOL:     r_x <= w_prod[63:0];
                OP_HEAT: begin
                    r_hneg <= w_heat[49];
                    r_x    <= {14'b0, w_heatmag};
                end
                OP_HEAT_DT:  r_x <= w_prod[63:0];
                default:     r_x <= r_x;
            endcase
        end

        if (r_state == ST_DONE && w_out_free) begin
            r_out_gear  <= r_gear;
            r_out_speed <= r_speed;
            r_out_wheel <= r_wheel;
            r_out_gbox  <= r_gbox;
            r_out_temp  <= r_temp;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_gear_engaged        = r_out_gear;
    assign o_vehicle_speed       = r_out_speed;
    assign o_wheel_rpm           = r_out_wheel;
    assign o_gearbox_rpm         = r_out_gbox;
    assign o_gearbox_temperature = r_out_temp;

endmodule

[rtl/dts_checker.sv]
// ----------------------------------------------------------------------------
// dts_checker
// port-level checks of the drivetrain thermal step core
// ----------------------------------------------------------------------------
`include "drivetrain_thermal_step_core_assert.svh"

module dts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_gear_engaged,
    input logic [23:0] o_vehicle_speed,
    input logic [19:0] o_wheel_rpm,
    input logic [23:0] o_gearbox_rpm
);

    // a step is running after every input transfer
    `DTS_ASSERT_NEXT(a_busy_after_in, i_in_valid && o_in_ready, !o_in_ready, "ready after transfer")

    // gearbox turns only with an engaged gear and a turning wheel
    `DTS_ASSERT_SAME(a_gbox_needs_wheel, o_out_valid && (o_gearbox_rpm != 24'd0), (o_wheel_rpm != 20'd0) && (o_gear_engaged != 3'd0), "gearbox rpm without wheel or gear")

    `DTS_ASSERT_SAME(a_gear_range, o_out_valid, o_gear_engaged <= 3'd5, "gear out of range")

    // stalled result holds its valid, speed and gearbox rpm
    `DTS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_vehicle_speed) && $stable(o_gearbox_rpm), "stalled result changed")

    `DTS_ASSERT_RESET(a_reset_clear, !o_out_valid && o_in_ready, "reset left handshakes set")

endmodule

bind drivetrain_thermal_step_core dts_checker u_dts_checker (.*);
